@@ rtl/ufs_pkg.sv @@
// Package with the result type, constants and the accented-letter fold table.
package ufs_pkg;

  // One result beat as it travels through the result queue.
  typedef struct packed {
    logic [7:0] out_char;
    logic       name_end;
    logic [7:0] name_length;
    logic       run_last;
  } ufs_res_t;

  // Result queue geometry: one input byte may push two beats.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0] LeadByte     = 8'hC3;
  localparam logic [7:0] Underscore   = 8'h5F;
  localparam logic [7:0] Space        = 8'h20;
  localparam logic [7:0] Hyphen       = 8'h2D;
  localparam logic [7:0] OutLimitRst  = 8'd31;

  typedef logic [15:0][7:0] ufs_tab_t;

  // Second bytes of the folded two-byte sequences, entry 0 in the low slot.
  localparam ufs_tab_t FoldSecond = {
    8'h9C, 8'hBC, 8'h87, 8'hA7, 8'h91, 8'hB1, 8'h9A, 8'h93,
    8'h8D, 8'h89, 8'h81, 8'hBA, 8'hB3, 8'hAD, 8'hA9, 8'hA1
  };

  // ASCII letters the sequences above fold to ("aeiouAEIOUnNcCuU").
  localparam ufs_tab_t FoldAscii = {
    8'h55, 8'h75, 8'h43, 8'h63, 8'h4E, 8'h6E, 8'h55, 8'h4F,
    8'h49, 8'h45, 8'h41, 8'h75, 8'h6F, 8'h69, 8'h65, 8'h61
  };

  // Look up a second byte; the hit flag is in the top bit of the result.
  function automatic logic [8:0] fold_lookup(input logic [7:0] b);
    logic [8:0] res;
    res = '0;
    for (int i = 0; i < 16; i++) begin
      if (FoldSecond[i] == b) begin
        res = {1'b1, FoldAscii[i]};
      end
    end
    return res;
  endfunction

  // Letters and digits pass through unchanged.
  function automatic logic is_alnum(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A)) ||
           ((b >= 8'h30) && (b <= 8'h39));
  endfunction

endpackage

@@ rtl/utf8_name_to_folder_sanitizer_top.sv @@
// Top level of the name to folder-name sanitizer.
//
//   Port group      Direction  Handshake              Content
//   in_*            input      in_valid_i/in_ready_o  in_byte_i
//   out_*           output     out_valid_o/out_ready_i out_char_o, name_end_o,
//                                                     name_length_o, run_last_o
//   out_limit_*     input      out_limit_we_i         out_limit_i
//
// A byte is decided in the cycle it is accepted and its results sit in the
// queue at the next edge. One byte per cycle is taken while the four-entry
// result queue has room for two beats; the output side hands out one beat per
// cycle while out_ready_i is high, so a held underscore costs an extra output
// beat. Reset clears the name state and the queue and sets the limit to 31.
// Output stalls back up into in_ready_o.
module utf8_name_to_folder_sanitizer_top import ufs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       name_end_o,
  output logic [7:0] name_length_o,
  output logic       run_last_o,
  input  logic       out_limit_we_i,
  input  logic [7:0] out_limit_i
);

  logic [7:0] limit_q;
  logic       take;
  logic [1:0] res_cnt;
  logic [1:0] push_cnt;
  ufs_res_t   res0, res1, head;

  // Length limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= OutLimitRst;
    end else if (out_limit_we_i) begin
      limit_q <= out_limit_i;
    end
  end

  assign take     = in_valid_i && in_ready_o;
  assign push_cnt = take ? res_cnt : 2'd0;

  ufs_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .in_byte_i  (in_byte_i),
    .out_limit_i(limit_q),
    .res_cnt_o  (res_cnt),
    .res0_o     (res0),
    .res1_o     (res1)
  );

  ufs_outq u_outq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_cnt_i(push_cnt),
    .push0_i   (res0),
    .push1_i   (res1),
    .room_o    (in_ready_o),
    .valid_o   (out_valid_o),
    .ready_i   (out_ready_i),
    .data_o    (head)
  );

  assign out_char_o    = head.out_char;
  assign name_end_o    = head.name_end;
  assign name_length_o = head.name_length;
  assign run_last_o    = head.run_last;

endmodule

@@ rtl/ufs_core.sv @@
// Per-byte decision logic and the name state registers.
module ufs_core import ufs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] in_byte_i,
  input  logic [7:0] out_limit_i,
  output logic [1:0] res_cnt_o,
  output ufs_res_t   res0_o,
  output ufs_res_t   res1_o
);

  logic       lead_q, lead_d;
  logic       after_sep_q, after_sep_d;
  logic       held_q, held_d;
  logic [7:0] count_q, count_d;

  logic [8:0] fold;
  logic [8:0] used;
  logic       emit;
  logic [7:0] emit_char;

  assign fold = fold_lookup(in_byte_i);
  assign used = {1'b0, count_q} + {8'd0, held_q};

  // Decide what this byte does to the name and which characters it yields.
  always_comb begin
    lead_d      = lead_q;
    after_sep_d = after_sep_q;
    held_d      = held_q;
    count_d     = count_q;
    emit        = 1'b0;
    emit_char   = in_byte_i;
    res_cnt_o   = 2'd0;
    res0_o      = '0;
    res1_o      = '0;

    if (in_byte_i == 8'd0) begin
      res_cnt_o   = 2'd1;
      res0_o      = '{out_char: 8'd0, name_end: 1'b1, name_length: count_q, run_last: 1'b1};
      lead_d      = 1'b0;
      after_sep_d = 1'b1;
      held_d      = 1'b0;
      count_d     = 8'd0;
    end else if (lead_q) begin
      lead_d    = 1'b0;
      emit      = fold[8];
      emit_char = fold[7:0];
    end else if (used >= {1'b0, out_limit_i}) begin
      // Name is full; the byte is ignored.
    end else if (in_byte_i == LeadByte) begin
      lead_d = 1'b1;
    end else if (is_alnum(in_byte_i)) begin
      emit = 1'b1;
    end else if ((in_byte_i == Space) || (in_byte_i == Hyphen) ||
                 (in_byte_i == Underscore)) begin
      if (!after_sep_q) begin
        held_d      = 1'b1;
        after_sep_d = 1'b1;
      end
    end

    // A character pays out a held underscore first.
    if (emit) begin
      held_d      = 1'b0;
      after_sep_d = 1'b0;
      if (held_q) begin
        res_cnt_o = 2'd2;
        res0_o    = '{out_char: Underscore, name_end: 1'b0, name_length: 8'd0,
                      run_last: 1'b0};
        res1_o    = '{out_char: emit_char, name_end: 1'b0, name_length: 8'd0,
                      run_last: 1'b1};
        count_d   = count_q + 8'd2;
      end else begin
        res_cnt_o = 2'd1;
        res0_o    = '{out_char: emit_char, name_end: 1'b0, name_length: 8'd0,
                      run_last: 1'b1};
        count_d   = count_q + 8'd1;
      end
    end
  end

  // Name state advances on each accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q      <= 1'b0;
      after_sep_q <= 1'b1;
      held_q      <= 1'b0;
      count_q     <= 8'd0;
    end else if (take_i) begin
      lead_q      <= lead_d;
      after_sep_q <= after_sep_d;
      held_q      <= held_d;
      count_q     <= count_d;
    end
  end

endmodule

@@ rtl/ufs_outq.sv @@
// Small result queue that takes up to two beats at once and hands out one per cycle while ready_i is high.
module ufs_outq import ufs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_cnt_i,
  input  ufs_res_t   push0_i,
  input  ufs_res_t   push1_i,
  output logic       room_o,
  output logic       valid_o,
  input  logic       ready_i,
  output ufs_res_t   data_o
);

  ufs_res_t             mem_q [QDepth];
  logic [QPtrW-1:0]     wptr_q, rptr_q;
  logic [QCntW-1:0]     cnt_q;
  logic                 pop;
  logic [QPtrW-1:0]     wptr1;

  // Room for the largest burst one byte can cause.
  assign room_o  = cnt_q <= QCntW'(QDepth - 2);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rptr_q];
  assign pop     = valid_o && ready_i;
  assign wptr1   = wptr_q + QPtrW'(1);

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wptr1] <= push1_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + QPtrW'(push_cnt_i);
      rptr_q <= rptr_q + QPtrW'(pop);
      cnt_q  <= cnt_q + QCntW'(push_cnt_i) - QCntW'(pop);
    end
  end

endmodule
